// File: sv/bba_pkg.sv
// shared constants and codes for the buddy block allocator
// used by bba_unit_mem and buddy_block_allocator_core; depends on nothing
package bba_pkg;

	// default geometry: orders above the minimum block, and top blocks in the pool
	localparam int LEVELS_DEF     = 10;
	localparam int TOP_BLOCKS_DEF = 4;

	// port field widths
	localparam int ORDER_W   = 4;
	localparam int ADDR_W    = 12;
	localparam int TOPUSED_W = 3;
	localparam int FREECNT_W = 13;

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OOM       = 2'd1,
		ST_BAD_ORDER = 2'd2,
		ST_BAD_FREE  = 2'd3
	} status_t;

endpackage

// File: sv/bba_unit_mem.sv
// per-unit state memory: free flag, order and list links of every minimum-block unit
// one write and one registered read port; clears itself after reset; uses bba_pkg
module bba_unit_mem #(
	parameter int DEPTH = bba_pkg::TOP_BLOCKS_DEF << bba_pkg::LEVELS_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int WW    = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [WW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [WW-1:0] rd_data,
	output logic          busy
);

	logic [WW-1:0] mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          busy_q;

	// clearing pass, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	// write port, taken over by the clearing pass
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, holds its data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign busy = busy_q;

endmodule

// File: sv/buddy_block_allocator_core.sv
// buddy block allocator: one request in, one result out, state in a unit memory.
// allocate: list scan up to the top order, unlink of the found block, one push per split order;
// free: check of the block and of each ancestor order, unlink of each merged buddy, and the push.
// one request at a time; the list walk through the single unit memory and its one read port sets the rate.
// after reset every entry of the unit memory is cleared, with s_axis_tready low.
// uses bba_pkg and bba_unit_mem
module buddy_block_allocator_core #(
	parameter int LEVELS     = bba_pkg::LEVELS_DEF,
	parameter int TOP_BLOCKS = bba_pkg::TOP_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // order[3:0], address[15:4]
	input  logic [0:0]  s_axis_tuser,   // kind[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // block_address[11:0], top_blocks_used[14:12],
	                                    // free_at_order[27:15], zero[31:28]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	localparam int UNITS   = TOP_BLOCKS << LEVELS;
	localparam int AW      = $clog2(UNITS);
	localparam int LW      = $clog2(UNITS + 1);
	localparam int OW      = $clog2(LEVELS + 1);
	localparam int TW      = $clog2(TOP_BLOCKS + 1);
	localparam int ORDERS  = LEVELS + 1;
	localparam int ADDR_WL = bba_pkg::ADDR_W;
	localparam logic [LW-1:0] NIL = LW'(UNITS);

	typedef struct packed {
		logic          free;
		logic [OW-1:0] ord;
		logic [LW-1:0] nxt;
		logic [LW-1:0] prv;
	} unit_t;

	typedef enum logic [4:0] {
		S_IDLE, S_ASCAN, S_ASPLIT, S_FSELF, S_FARD, S_FACHK, S_MRG, S_MCHK,
		S_U0, S_U1, S_U2, S_U3, S_U4, S_P0, S_P1, S_FIN
	} state_t;

	state_t                 state_q, ret_q;
	bba_pkg::status_t       status_q;
	logic                   ord_bad_q;
	logic [OW-1:0]          ord_q, k_q, pj_q;
	logic [LW-1:0]          blk_q, res_q, ua_q, un_q, up_q, pa_q, ph_q;
	logic [LW-1:0]          head_q [ORDERS];
	logic [LW-1:0]          cnt_q [ORDERS];
	logic [TW-1:0]          top_q;
	logic                   m_valid_q;
	logic [1:0]             m_user_q;
	logic [31:0]            m_data_q;

	logic                   mem_we, mem_re, mem_busy;
	logic [AW-1:0]          mem_wa, mem_ra;
	unit_t                  mem_wd, rd;
	logic [$bits(unit_t)-1:0] mem_rd;

	logic [3:0]             in_ord4;
	logic [ADDR_WL-1:0]     in_addr;
	logic                   in_kind, accept, ord_bad, misalign, out_range;
	logic [OW-1:0]          in_ord;
	logic [LW-1:0]          anc, mrg_b;

	assign rd = unit_t'(mem_rd);

	// request decode
	assign in_ord4   = s_axis_tdata[3:0];
	assign in_addr   = s_axis_tdata[15:4];
	assign in_kind   = s_axis_tuser[0];
	assign s_axis_tready = (state_q == S_IDLE) && !mem_busy;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign ord_bad   = 32'(in_ord4) > LEVELS;
	assign in_ord    = ord_bad ? '0 : OW'(in_ord4);
	assign misalign  = (32'(in_addr) & ((32'd1 << in_ord4) - 32'd1)) != 32'd0;
	assign out_range = 32'(in_addr) >= (32'(top_q) << LEVELS);

	// ancestor start and buddy address
	assign anc   = blk_q & ({LW{1'b1}} << k_q);
	assign mrg_b = blk_q ^ (LW'(1) << k_q);

	// unit memory request
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !ord_bad && in_kind == bba_pkg::KIND_FREE
					&& !misalign && !out_range) begin
					mem_re = 1'b1;
					mem_ra = AW'(in_addr);
				end
			end
			S_FARD: begin
				mem_re = 1'b1;
				mem_ra = anc[AW-1:0];
			end
			S_MRG: begin
				if (32'(k_q) != LEVELS) begin
					mem_re = 1'b1;
					mem_ra = mrg_b[AW-1:0];
				end
			end
			S_U0: begin
				mem_re = 1'b1;
				mem_ra = ua_q[AW-1:0];
			end
			S_U1: begin
				mem_we = 1'b1;
				mem_wa = ua_q[AW-1:0];
				mem_wd = '{free: 1'b0, ord: rd.ord, nxt: NIL, prv: NIL};
				if (rd.prv != NIL) begin
					mem_re = 1'b1;
					mem_ra = rd.prv[AW-1:0];
				end
			end
			S_U2: begin
				mem_we     = 1'b1;
				mem_wa     = up_q[AW-1:0];
				mem_wd     = rd;
				mem_wd.nxt = un_q;
			end
			S_U3: begin
				if (un_q != NIL) begin
					mem_re = 1'b1;
					mem_ra = un_q[AW-1:0];
				end
			end
			S_U4: begin
				mem_we     = 1'b1;
				mem_wa     = un_q[AW-1:0];
				mem_wd     = rd;
				mem_wd.prv = up_q;
			end
			S_P0: begin
				mem_we = 1'b1;
				mem_wa = pa_q[AW-1:0];
				mem_wd = '{free: 1'b1, ord: pj_q, nxt: head_q[pj_q], prv: NIL};
				if (head_q[pj_q] != NIL) begin
					mem_re = 1'b1;
					mem_ra = head_q[pj_q][AW-1:0];
				end
			end
			S_P1: begin
				mem_we     = 1'b1;
				mem_wa     = ph_q[AW-1:0];
				mem_wd     = rd;
				mem_wd.prv = pa_q;
			end
			default: begin
			end
		endcase
	end

	bba_unit_mem #(
		.DEPTH (UNITS),
		.AW    (AW),
		.WW    ($bits(unit_t))
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_we),
		.wr_addr (mem_wa),
		.wr_data (mem_wd),
		.rd_en   (mem_re),
		.rd_addr (mem_ra),
		.rd_data (mem_rd),
		.busy    (mem_busy)
	);

	// sequencer, list heads and counts, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			status_q  <= bba_pkg::ST_OK;
			ord_bad_q <= 1'b0;
			ord_q     <= '0;
			k_q       <= '0;
			pj_q      <= '0;
			blk_q     <= '0;
			res_q     <= '0;
			ua_q      <= '0;
			un_q      <= '0;
			up_q      <= '0;
			pa_q      <= '0;
			ph_q      <= '0;
			top_q     <= '0;
			for (int i = 0; i < ORDERS; i++) begin
				head_q[i] <= NIL;
				cnt_q[i]  <= '0;
			end
			m_valid_q <= 1'b0;
			m_user_q  <= '0;
			m_data_q  <= '0;
		end else begin
			// result taken; the result load below handles its own state
			if (m_valid_q && m_axis_tready && state_q != S_FIN) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ord_bad_q <= ord_bad;
						ord_q     <= in_ord;
						k_q       <= in_ord;
						blk_q     <= LW'(in_addr);
						res_q     <= '0;
						status_q  <= bba_pkg::ST_OK;
						priority if (ord_bad) begin
							status_q <= bba_pkg::ST_BAD_ORDER;
							state_q  <= S_FIN;
						end else if (in_kind == bba_pkg::KIND_ALLOC) begin
							state_q <= S_ASCAN;
						end else if (misalign || out_range) begin
							status_q <= bba_pkg::ST_BAD_FREE;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_FSELF;
						end
					end
				end
				// find the smallest nonempty list at or above the order, else take a new top block
				S_ASCAN: begin
					priority if (head_q[k_q] != NIL) begin
						blk_q   <= head_q[k_q];
						ua_q    <= head_q[k_q];
						ret_q   <= S_ASPLIT;
						state_q <= S_U0;
					end else if (32'(k_q) == LEVELS) begin
						if (32'(top_q) < TOP_BLOCKS) begin
							blk_q   <= LW'(32'(top_q) << LEVELS);
							top_q   <= top_q + 1'b1;
							state_q <= S_ASPLIT;
						end else begin
							status_q <= bba_pkg::ST_OOM;
							state_q  <= S_FIN;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				// push upper halves down to the requested order
				S_ASPLIT: begin
					if (k_q != ord_q) begin
						pa_q    <= blk_q + (LW'(1) << (k_q - 1'b1));
						pj_q    <= k_q - 1'b1;
						k_q     <= k_q - 1'b1;
						ret_q   <= S_ASPLIT;
						state_q <= S_P0;
					end else begin
						res_q   <= blk_q;
						state_q <= S_FIN;
					end
				end
				// double free check on the block itself
				S_FSELF: begin
					priority if (rd.free) begin
						status_q <= bba_pkg::ST_BAD_FREE;
						state_q  <= S_FIN;
					end else if (32'(ord_q) == LEVELS) begin
						k_q     <= ord_q;
						state_q <= S_MRG;
					end else begin
						k_q     <= ord_q + 1'b1;
						state_q <= S_FARD;
					end
				end
				S_FARD: begin
					state_q <= S_FACHK;
				end
				// covered by a larger free block
				S_FACHK: begin
					priority if (rd.free && rd.ord >= k_q) begin
						status_q <= bba_pkg::ST_BAD_FREE;
						state_q  <= S_FIN;
					end else if (32'(k_q) == LEVELS) begin
						k_q     <= ord_q;
						state_q <= S_MRG;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_FARD;
					end
				end
				S_MRG: begin
					if (32'(k_q) != LEVELS) begin
						state_q <= S_MCHK;
					end else begin
						pa_q    <= blk_q;
						pj_q    <= k_q;
						ret_q   <= S_FIN;
						state_q <= S_P0;
					end
				end
				// merge with a free buddy of the same order
				S_MCHK: begin
					if (rd.free && rd.ord == k_q) begin
						ua_q    <= mrg_b;
						blk_q   <= (mrg_b < blk_q) ? mrg_b : blk_q;
						k_q     <= k_q + 1'b1;
						ret_q   <= S_MRG;
						state_q <= S_U1;
					end else begin
						pa_q    <= blk_q;
						pj_q    <= k_q;
						ret_q   <= S_FIN;
						state_q <= S_P0;
					end
				end
				// unlink ua_q from its list
				S_U0: begin
					state_q <= S_U1;
				end
				S_U1: begin
					un_q          <= rd.nxt;
					up_q          <= rd.prv;
					cnt_q[rd.ord] <= cnt_q[rd.ord] - 1'b1;
					if (rd.prv != NIL) begin
						state_q <= S_U2;
					end else begin
						head_q[rd.ord] <= rd.nxt;
						state_q        <= S_U3;
					end
				end
				S_U2: begin
					state_q <= S_U3;
				end
				S_U3: begin
					state_q <= (un_q != NIL) ? S_U4 : ret_q;
				end
				S_U4: begin
					state_q <= ret_q;
				end
				// push pa_q at the head of list pj_q
				S_P0: begin
					ph_q         <= head_q[pj_q];
					head_q[pj_q] <= pa_q;
					cnt_q[pj_q]  <= cnt_q[pj_q] + 1'b1;
					state_q      <= (head_q[pj_q] != NIL) ? S_P1 : ret_q;
				end
				S_P1: begin
					state_q <= ret_q;
				end
				// load the result register
				S_FIN: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_user_q  <= status_q;
						m_data_q  <= {4'd0,
							ord_bad_q ? 13'd0 : 13'(cnt_q[ord_q]),
							3'(top_q),
							12'(res_q)};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tdata  = m_data_q;

	// no request taken while the memory is being cleared
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !s_axis_tready)
		else $error("request accepted during clearing pass");

	// no same-entry read and write in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_wa != mem_ra))
		else $error("read and write of one entry in the same cycle");

	// an empty order 0 list has a zero count
	a_head_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q[0] == NIL) |-> (cnt_q[0] == '0))
		else $error("empty order 0 list with nonzero count");

	// top block count within the pool
	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(top_q) <= TOP_BLOCKS)
		else $error("top block count beyond pool");

	// out of memory only once every top block is taken
	a_oom_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && status_q == bba_pkg::ST_OOM) |-> (32'(top_q) == TOP_BLOCKS))
		else $error("out of memory with top blocks left");

endmodule
